// ===== rtl/core/ttip_pkg.sv =====
package ttip_pkg;

  localparam int DEF_LONG_BITS   = 32;
  localparam int DEF_OFFSET_BITS = 16;
  localparam int END_W           = 16;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_ZEROX,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    MODE_U64,
    MODE_S64,
    MODE_SLONG,
    MODE_ULONG
  } mode_t;

  // register indexes on the config port
  localparam logic CFG_NUMBER_BASE = 1'b0;
  localparam logic CFG_MODE        = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_ONE  = 6'd1;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;
  localparam logic [5:0] BASE_MAX  = 6'd36;

  // larger than any legal radix
  localparam logic [5:0] DIGIT_NONE = 6'h3F;

  typedef struct packed {
    logic [63:0]      value;
    logic             ovf;
    logic             minus;
    logic [END_W-1:0] end_offset;
    logic             digits;
    mode_t            mode;
  } res_raw_t;

  typedef struct packed {
    logic [63:0]      value_bits;
    logic             overflow_seen;
    logic             minus_sign;
    logic [END_W-1:0] end_offset;
    logic             digits_found;
  } res_out_t;

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [5:0] d;
    d = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 6'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = 6'(c - CH_LO_A + 8'd10);
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = 6'(c - CH_UP_A + 8'd10);
    end
    return d;
  endfunction

endpackage

// ===== rtl/core/ttip_in_if.sv =====
interface ttip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink (input valid, input text_char, input last_char, output ready);
endinterface

// ===== rtl/core/ttip_out_if.sv =====
interface ttip_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  logic        overflow_seen;
  logic        minus_sign;
  logic [15:0] end_offset;
  logic        digits_found;

  modport source (
    output valid, output value_bits, output overflow_seen, output minus_sign,
    output end_offset, output digits_found, input ready
  );
  modport sink (
    input valid, input value_bits, input overflow_seen, input minus_sign,
    input end_offset, input digits_found, output ready
  );
endinterface

// ===== rtl/core/ttip_accum.sv =====
module ttip_accum
  import ttip_pkg::*;
(
  input  logic [63:0] acc_in,
  input  logic [5:0]  base,
  input  logic [5:0]  digit,
  output logic [63:0] acc_out,
  output logic        ovf
);

  // 64x6 product plus digit; anything above bit 63 is an overflow
  logic [69:0] prod;
  logic [69:0] sum;

  assign prod    = 70'(acc_in) * 70'(base);
  assign sum     = prod + 70'(digit);
  assign ovf     = |sum[69:64];
  assign acc_out = ovf ? '1 : sum[63:0];

endmodule

// ===== rtl/core/ttip_convert.sv =====
module ttip_convert
  import ttip_pkg::*;
#(
  parameter int LONG_BITS = DEF_LONG_BITS
) (
  input  res_raw_t raw,
  output res_out_t res
);

  // shift in two steps so LONG_BITS = 64 gives all ones
  localparam logic [63:0] LongMask = ((64'd1 << (LONG_BITS - 1)) << 1) - 64'd1;
  localparam logic [63:0] LongMax  = LongMask >> 1;
  localparam logic [63:0] LongMin  = (LongMax + 64'd1) & LongMask;

  logic [63:0] neg;
  logic [63:0] signed_v;
  logic [63:0] conv;

  assign neg      = 64'd0 - raw.value;
  assign signed_v = raw.minus ? neg : raw.value;

  always_comb begin
    case (raw.mode)
      MODE_U64: conv = raw.value;
      MODE_S64: begin
        if (raw.ovf) begin
          conv = raw.minus ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
          conv = signed_v;
        end
      end
      MODE_SLONG: begin
        if (raw.ovf) begin
          conv = raw.minus ? LongMin : LongMax;
        end else begin
          conv = signed_v & LongMask;
        end
      end
      MODE_ULONG: conv = signed_v & LongMask;
      default:    conv = raw.value;
    endcase
  end

  assign res.value_bits    = raw.digits ? conv : 64'd0;
  assign res.overflow_seen = raw.ovf;
  assign res.minus_sign    = raw.minus;
  assign res.end_offset    = raw.end_offset;
  assign res.digits_found  = raw.digits;

endmodule

// ===== rtl/core/text_to_integer_parser.sv =====
// Pipeline: the character ending the number goes through the input register,
//   the parse step into the raw result register and conversion to out_ch.
// Throughput: one character per cycle unless results back up; the parse step
//   (one 64x6 multiply-add with overflow check) carries the state to the next char.
// Reset (rst_n low, synchronous): pipeline empty, parser back to whitespace
//   skipping, number_base and mode cleared to zero.
module text_to_integer_parser
  import ttip_pkg::*;
#(
  parameter int LONG_BITS   = DEF_LONG_BITS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  ttip_in_if.sink           in_ch,
  ttip_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [5:0]        cfg_data
);

  localparam int EndW = (OFFSET_BITS < END_W) ? OFFSET_BITS : END_W;

  // config
  logic [5:0] base_cfg_r;
  mode_t      mode_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  // parser state
  phase_t                 phase_r, phase_step, phase_nxt;
  logic [5:0]             base_r, base_nxt;
  logic [63:0]            acc_r;
  logic                   sign_r, sign_nxt;
  logic                   ovf_r;
  logic [OFFSET_BITS-1:0] pos_r, pos_sat;
  logic [OFFSET_BITS-1:0] end_r;

  // raw result and output registers
  logic     r1_valid_r;
  res_raw_t r1_r, r1_nxt;
  logic     out_valid_r;
  res_out_t out_r, conv_res;

  // step decode
  logic        is_space, is_sign, is_x, base_inv, zero_pref, start_ph;
  logic [5:0]  dig, base_start, acc_base;
  logic        do_acc, acc_from_zero;
  logic        emit_step, step_dig, step_zero;
  logic        emit, emit_dig, emit_zero;
  logic [63:0] acc_in, acc_new, val_post;
  logic        acc_ovf, ovf_post;
  logic [OFFSET_BITS-1:0] end_post;
  logic        proc, out_load;

  assign dig       = digit_of(s1_char_r);
  assign is_space  = (s1_char_r == CH_SPACE) || (s1_char_r >= CH_TAB && s1_char_r <= CH_CR);
  assign is_sign   = (s1_char_r == CH_PLUS) || (s1_char_r == CH_MINUS);
  assign is_x      = (s1_char_r == CH_LO_X) || (s1_char_r == CH_UP_X);
  assign base_inv  = (base_cfg_r == BASE_ONE) || (base_cfg_r > BASE_MAX);
  assign base_start = (base_cfg_r == BASE_AUTO) ?
                      ((s1_char_r == CH_ZERO) ? BASE_OCT : BASE_DEC) : base_cfg_r;
  assign zero_pref = (s1_char_r == CH_ZERO) &&
                     ((base_cfg_r == BASE_AUTO) || (base_cfg_r == BASE_HEX));
  assign start_ph  = (phase_r == PH_SIGNED) ||
                     ((phase_r == PH_SPACE) && !is_space && !is_sign);

  // next state
  always_comb begin
    phase_step = phase_r;
    case (phase_r)
      PH_SPACE, PH_SIGNED: begin
        if (start_ph) begin
          if (base_inv) begin
            phase_step = PH_DONE;
          end else if (dig < base_start) begin
            phase_step = zero_pref ? PH_ZERO : PH_DIGITS;
          end else begin
            phase_step = PH_DONE;
          end
        end else if (is_sign) begin
          phase_step = PH_SIGNED;
        end
      end
      PH_ZERO: begin
        if (is_x) begin
          phase_step = PH_ZEROX;
        end else begin
          phase_step = (dig < base_r) ? PH_DIGITS : PH_DONE;
        end
      end
      PH_ZEROX:  phase_step = (dig < BASE_HEX) ? PH_DIGITS : PH_DONE;
      PH_DIGITS: phase_step = (dig < base_r) ? PH_DIGITS : PH_DONE;
      PH_DONE:   phase_step = PH_DONE;
      default:   phase_step = PH_DONE;
    endcase
    phase_nxt = s1_last_r ? PH_SPACE : phase_step;
  end

  // step actions
  always_comb begin
    do_acc        = 1'b0;
    acc_from_zero = 1'b0;
    emit_step     = 1'b0;
    step_dig      = 1'b0;
    step_zero     = 1'b0;
    base_nxt      = base_r;
    sign_nxt      = sign_r;
    case (phase_r)
      PH_SPACE, PH_SIGNED: begin
        if (start_ph) begin
          if (base_inv) begin
            emit_step = 1'b1;
            step_zero = 1'b1;
          end else begin
            base_nxt = base_start;
            if (dig < base_start) begin
              do_acc = 1'b1;
            end else begin
              emit_step = 1'b1;
            end
          end
        end else if (is_sign) begin
          sign_nxt = (s1_char_r == CH_MINUS);
        end
      end
      PH_ZERO: begin
        if (!is_x) begin
          if (dig < base_r) begin
            do_acc = 1'b1;
          end else begin
            emit_step = 1'b1;
            step_dig  = 1'b1;
          end
        end
      end
      PH_ZEROX: begin
        if (dig < BASE_HEX) begin
          do_acc        = 1'b1;
          acc_from_zero = 1'b1;
          base_nxt      = BASE_HEX;
        end else begin
          emit_step = 1'b1;
          step_dig  = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (dig < base_r) begin
          do_acc = 1'b1;
        end else begin
          emit_step = 1'b1;
          step_dig  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // the last char closes an open number
  always_comb begin
    emit      = emit_step;
    emit_dig  = step_dig;
    emit_zero = step_zero;
    if (s1_last_r && !emit_step && phase_step != PH_DONE) begin
      emit      = 1'b1;
      emit_dig  = !(phase_step == PH_SPACE || phase_step == PH_SIGNED);
      emit_zero = (phase_step == PH_SPACE || phase_step == PH_SIGNED) && base_inv;
    end
  end

  assign acc_base = (phase_r == PH_ZEROX) ? BASE_HEX :
                    (start_ph ? base_start : base_r);
  assign acc_in   = acc_from_zero ? 64'd0 : acc_r;

  ttip_accum u_accum (
    .acc_in  (acc_in),
    .base    (acc_base),
    .digit   (dig),
    .acc_out (acc_new),
    .ovf     (acc_ovf)
  );

  assign pos_sat  = (pos_r == '1) ? pos_r : pos_r + OFFSET_BITS'(1);
  assign val_post = do_acc ? acc_new : acc_r;
  assign ovf_post = ovf_r | (do_acc & acc_ovf);
  assign end_post = do_acc ? pos_sat : end_r;

  always_comb begin
    r1_nxt.value      = val_post;
    r1_nxt.ovf        = emit_dig & ovf_post;
    r1_nxt.minus      = sign_nxt & !emit_zero;
    r1_nxt.end_offset = emit_dig ? END_W'(end_post[EndW-1:0]) : '0;
    r1_nxt.digits     = emit_dig & !emit_zero;
    r1_nxt.mode       = mode_r;
  end

  // handshakes
  assign out_load    = r1_valid_r && (!out_valid_r || out_ch.ready);
  assign proc        = s1_valid_r && (!emit || !r1_valid_r || out_load);
  assign in_ch.ready = !s1_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cfg_r <= BASE_AUTO;
      mode_r     <= MODE_U64;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NUMBER_BASE) begin
        base_cfg_r <= cfg_data;
      end else if (cfg_index == CFG_MODE) begin
        mode_r <= mode_t'(cfg_data[1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.text_char;
      s1_last_r <= in_ch.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
      base_r  <= BASE_AUTO;
      acc_r   <= '0;
      sign_r  <= 1'b0;
      ovf_r   <= 1'b0;
      pos_r   <= '0;
      end_r   <= '0;
    end else if (proc) begin
      phase_r <= phase_nxt;
      if (s1_last_r) begin
        base_r <= BASE_AUTO;
        acc_r  <= '0;
        sign_r <= 1'b0;
        ovf_r  <= 1'b0;
        pos_r  <= '0;
        end_r  <= '0;
      end else begin
        base_r <= base_nxt;
        acc_r  <= val_post;
        sign_r <= sign_nxt;
        ovf_r  <= ovf_post;
        pos_r  <= pos_sat;
        end_r  <= end_post;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_valid_r <= 1'b0;
    end else begin
      r1_valid_r <= (r1_valid_r && !out_load) || (proc && emit);
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      r1_r <= r1_nxt;
    end
  end

  ttip_convert #(
    .LONG_BITS (LONG_BITS)
  ) u_convert (
    .raw (r1_r),
    .res (conv_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && !out_ch.ready) || out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= conv_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.value_bits    = out_r.value_bits;
  assign out_ch.overflow_seen = out_r.overflow_seen;
  assign out_ch.minus_sign    = out_r.minus_sign;
  assign out_ch.end_offset    = out_r.end_offset;
  assign out_ch.digits_found  = out_r.digits_found;

  // a string's last char always leaves the parser clean for the next one
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_last_r |=> phase_r == PH_SPACE && acc_r == 64'd0 && pos_r == '0)
    else $error("parser state not cleared after last char");

  // once a number is closed the rest of the string gives no result
  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && phase_r == PH_DONE |-> !emit)
    else $error("result emitted after number was closed");

  // a pending raw result is never dropped
  a_r1_kept: assert property (@(posedge clk) disable iff (!rst_n)
    r1_valid_r && !out_load |=> r1_valid_r)
    else $error("pending raw result lost");

  a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.digits_found |->
      out_ch.value_bits == 64'd0 && out_ch.end_offset == 16'd0 && !out_ch.overflow_seen)
    else $error("nonzero value without digits");

endmodule
